### sv/csq_pkg.sv
// ----------------------------------------------------------------------------
// csq_pkg
// Shared types and constants for the counting semaphore with wait queue.
// ----------------------------------------------------------------------------
package csq_pkg;

    localparam int WAIT_DEPTH_DEF   = 16;
    localparam int TASK_ID_BITS_DEF = 6;
    localparam int COUNT_BITS_DEF   = 16;
    localparam int CFG_BITS         = 15;

    typedef enum logic [1:0] {
        CMD_DOWN    = 2'd0,
        CMD_UP      = 2'd1,
        CMD_DESTROY = 2'd2
    } t_cmd;

    // spare command code, accepted and ignored
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        ST_GRANTED       = 3'd0,
        ST_BLOCKED       = 3'd1,
        ST_WOKEN         = 3'd2,
        ST_DESTROY_WOKEN = 3'd3,
        ST_DESTROY_DONE  = 3'd4,
        ST_DEAD_ERR      = 3'd5,
        ST_FULL_ERR      = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EMIT = 2'd1,
        S_POP  = 2'd2
    } t_state;

    typedef struct packed {
        logic busy;
        logic dead;
    } t_csq_stat;

endpackage

### sv/csq_if.sv
// ----------------------------------------------------------------------------
// csq_if
// Valid/ready channels: command input, result output, configuration write.
// ----------------------------------------------------------------------------
interface csq_cmd_if #(
    parameter int TASK_ID_BITS = 6
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              command;
    logic [TASK_ID_BITS-1:0] task_id;

    modport source (output valid, command, task_id, input ready);
    modport sink   (input valid, command, task_id, output ready);
endinterface

interface csq_res_if #(
    parameter int TASK_ID_BITS = 6,
    parameter int COUNT_BITS   = 16
);
    logic                         valid;
    logic                         ready;
    logic [2:0]                   status;
    logic [TASK_ID_BITS-1:0]      affected_task;
    logic signed [COUNT_BITS-1:0] count_after;
    logic                         last;

    modport source (output valid, status, affected_task, count_after, last, input ready);
    modport sink   (input valid, status, affected_task, count_after, last, output ready);
endinterface

interface csq_cfg_if #(
    parameter int CFG_BITS = 15
);
    logic                valid;
    logic                ready;
    logic [CFG_BITS-1:0] initial_count;

    modport source (output valid, initial_count, input ready);
    modport sink   (input valid, initial_count, output ready);
endinterface

### sv/counting_semaphore_wait_queue.sv
// Results: a down, up or error result goes through the pending registers, then the output
//   register; an up that wakes a waiter reads the memory and loads its data into the output.
// Ordering: a new command is taken only once the last result is in the output register;
//   a destroy drains one waiter per cycle through the memory read port, unless output stalls.
// Reset: count 0, queue empty, not destroyed; the waiter memory is not cleared.
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue
// Counting semaphore with a FIFO wait queue of task ids held in a RAM.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue #(
    parameter int WAIT_DEPTH   = csq_pkg::WAIT_DEPTH_DEF,
    parameter int TASK_ID_BITS = csq_pkg::TASK_ID_BITS_DEF,
    parameter int COUNT_BITS   = csq_pkg::COUNT_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    csq_cmd_if.sink   i_cmd,
    csq_res_if.source o_res,
    csq_cfg_if.sink   i_cfg
);
    import csq_pkg::*;

    localparam int PW = $clog2(WAIT_DEPTH);

    logic                    wr_en;
    logic [PW-1:0]           wr_addr;
    logic [TASK_ID_BITS-1:0] wr_data;
    logic                    rd_en;
    logic [PW-1:0]           rd_addr;
    logic [TASK_ID_BITS-1:0] rd_data;
    t_csq_stat               stat;

    csq_ctrl #(
        .WAIT_DEPTH   (WAIT_DEPTH),
        .TASK_ID_BITS (TASK_ID_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_res     (o_res),
        .i_cfg     (i_cfg),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_stat    (stat)
    );

    csq_ram #(
        .WIDTH (TASK_ID_BITS),
        .DEPTH (WAIT_DEPTH)
    ) u_wait_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready && (i_cmd.command != CMD_UNUSED)) |=> stat.busy)
        else $error("command transfer did not start a sequence");

    a_cfg_revive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.valid && i_cfg.ready) |=> !stat.dead)
        else $error("config write did not clear destroyed state");

    a_drain_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((o_res.status == 3'(ST_DESTROY_WOKEN)) == !o_res.last))
        else $error("last flag does not match destroy drain");

    a_dead_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status == 3'(ST_DEAD_ERR))) |-> stat.dead)
        else $error("destroyed error while semaphore alive");
`endif

endmodule

### sv/csq_ram.sv
// ----------------------------------------------------------------------------
// csq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/csq_ctrl.sv
// ----------------------------------------------------------------------------
// csq_ctrl
// Semaphore sequencer: permit count, queue pointers, dead flag, result
// register, and read/write control of the waiter memory.
// ----------------------------------------------------------------------------
module csq_ctrl #(
    parameter int WAIT_DEPTH   = 16,
    parameter int TASK_ID_BITS = 6,
    parameter int COUNT_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    csq_cmd_if.sink                       i_cmd,
    csq_res_if.source                     o_res,
    csq_cfg_if.sink                       i_cfg,
    output logic                          o_wr_en,
    output logic [$clog2(WAIT_DEPTH)-1:0] o_wr_addr,
    output logic [TASK_ID_BITS-1:0]       o_wr_data,
    output logic                          o_rd_en,
    output logic [$clog2(WAIT_DEPTH)-1:0] o_rd_addr,
    input  logic [TASK_ID_BITS-1:0]       i_rd_data,
    output csq_pkg::t_csq_stat            o_stat
);
    import csq_pkg::*;

    localparam int PW = $clog2(WAIT_DEPTH);
    localparam int TW = $clog2(WAIT_DEPTH + 1);
    localparam int CW = (COUNT_BITS > CFG_BITS + 1) ? COUNT_BITS : CFG_BITS + 1;
    localparam logic [63:0] CNT_MAX64 = (64'd1 << (COUNT_BITS - 1)) - 64'd1;
    localparam logic [CW-1:0] CFG_SAT = CW'(CNT_MAX64);
    localparam logic signed [COUNT_BITS-1:0] CNT_MAX = COUNT_BITS'(CNT_MAX64);
    localparam logic [PW-1:0] LAST_SLOT = PW'(WAIT_DEPTH - 1);
    localparam logic [TW-1:0] FULL_TOTAL = TW'(WAIT_DEPTH);

    t_state                       r_state, n_state;
    logic signed [COUNT_BITS-1:0] r_count, n_count;
    logic [PW-1:0]                r_head, n_head;
    logic [PW-1:0]                r_tail, n_tail;
    logic [TW-1:0]                r_total, n_total;
    logic                         r_dead, n_dead;
    logic                         r_drain, n_drain;
    t_status                      r_pend_status, n_pend_status;
    logic [TASK_ID_BITS-1:0]      r_pend_task, n_pend_task;
    logic                         r_ov, n_ov;
    t_status                      r_out_status, n_out_status;
    logic [TASK_ID_BITS-1:0]      r_out_task, n_out_task;
    logic signed [COUNT_BITS-1:0] r_out_count, n_out_count;
    logic                         r_out_last, n_out_last;

    logic          in_xfer;
    logic          out_free;
    logic          cnt_le_zero;
    logic [CW-1:0] cfg_ext;
    logic [CW-1:0] cfg_sat;

    function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PW'(1);
    endfunction

    assign i_cmd.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_xfer     = i_cmd.valid && i_cmd.ready;
    assign out_free    = !r_ov || o_res.ready;
    assign cnt_le_zero = r_count[COUNT_BITS-1] || (r_count == '0);
    assign cfg_ext     = CW'(i_cfg.initial_count);
    assign cfg_sat     = (cfg_ext > CFG_SAT) ? CFG_SAT : cfg_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_total <= '0;
            r_dead  <= 1'b0;
            r_drain <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_total <= n_total;
            r_dead  <= n_dead;
            r_drain <= n_drain;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_status <= n_pend_status;
        r_pend_task   <= n_pend_task;
        r_out_status  <= n_out_status;
        r_out_task    <= n_out_task;
        r_out_count   <= n_out_count;
        r_out_last    <= n_out_last;
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_head        = r_head;
        n_tail        = r_tail;
        n_total       = r_total;
        n_dead        = r_dead;
        n_drain       = r_drain;
        n_pend_status = r_pend_status;
        n_pend_task   = r_pend_task;
        n_ov          = r_ov;
        n_out_status  = r_out_status;
        n_out_task    = r_out_task;
        n_out_count   = r_out_count;
        n_out_last    = r_out_last;
        o_wr_en       = 1'b0;
        o_rd_en       = 1'b0;

        if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && (i_cmd.command != CMD_UNUSED)) begin
                    n_pend_task = '0;
                    if (r_dead) begin
                        n_pend_status = ST_DEAD_ERR;
                        n_state       = S_EMIT;
                    end else begin
                        unique case (t_cmd'(i_cmd.command))
                            CMD_DOWN: begin
                                n_state = S_EMIT;
                                if (cnt_le_zero) begin
                                    if (r_total >= FULL_TOTAL) begin
                                        n_pend_status = ST_FULL_ERR;
                                    end else begin
                                        o_wr_en       = 1'b1;
                                        n_tail        = next_slot(r_tail);
                                        n_total       = r_total + TW'(1);
                                        n_count       = r_count - COUNT_BITS'(1);
                                        n_pend_status = ST_BLOCKED;
                                        n_pend_task   = i_cmd.task_id;
                                    end
                                end else begin
                                    n_count       = r_count - COUNT_BITS'(1);
                                    n_pend_status = ST_GRANTED;
                                end
                            end
                            CMD_UP: begin
                                if (r_count == CNT_MAX) begin
                                    n_pend_status = ST_FULL_ERR;
                                    n_state       = S_EMIT;
                                end else begin
                                    n_count = r_count + COUNT_BITS'(1);
                                    if (r_count[COUNT_BITS-1] && (r_total != '0)) begin
                                        o_rd_en = 1'b1;
                                        n_drain = 1'b0;
                                        n_state = S_POP;
                                    end else begin
                                        n_pend_status = ST_GRANTED;
                                        n_state       = S_EMIT;
                                    end
                                end
                            end
                            CMD_DESTROY: begin
                                n_dead = 1'b1;
                                if (r_total != '0) begin
                                    o_rd_en = 1'b1;
                                    n_drain = 1'b1;
                                    n_state = S_POP;
                                end else begin
                                    n_pend_status = ST_DESTROY_DONE;
                                    n_state       = S_EMIT;
                                end
                            end
                            default: begin
                                n_state = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov         = 1'b1;
                    n_out_status = r_pend_status;
                    n_out_task   = r_pend_task;
                    n_out_count  = r_count;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_POP: begin
                if (out_free) begin
                    n_ov         = 1'b1;
                    n_out_status = r_drain ? ST_DESTROY_WOKEN : ST_WOKEN;
                    n_out_task   = i_rd_data;
                    n_out_count  = r_count;
                    n_out_last   = !r_drain;
                    n_head       = next_slot(r_head);
                    n_total      = r_total - TW'(1);
                    if (!r_drain) begin
                        n_state = S_IDLE;
                    end else if (r_total > TW'(1)) begin
                        o_rd_en = 1'b1;
                    end else begin
                        n_pend_status = ST_DESTROY_DONE;
                        n_pend_task   = '0;
                        n_state       = S_EMIT;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg.valid && i_cfg.ready) begin
            n_count = COUNT_BITS'(cfg_sat);
            n_head  = '0;
            n_tail  = '0;
            n_total = '0;
            n_dead  = 1'b0;
        end
    end

    assign o_wr_addr = r_tail;
    assign o_wr_data = i_cmd.task_id;
    assign o_rd_addr = n_head;

    assign o_res.valid         = r_ov;
    assign o_res.status        = r_out_status;
    assign o_res.affected_task = r_out_task;
    assign o_res.count_after   = r_out_count;
    assign o_res.last          = r_out_last;

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.dead = r_dead;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the counting semaphore with FIFO wait queue.
// Directed checks cover grants, blocking and wake order, a full wait queue,
// count saturation, destroy with a full drain, post-destroy errors and the
// unused command. A long output hold fills the block, then random sequences
// run under several initial counts. A local semaphore model predicts every
// result and a sink process compares each transfer in order.
// ----------------------------------------------------------------------------
module testbench;
    import csq_pkg::*;

    localparam int          COUNT_MAX   = 2 ** (COUNT_BITS_DEF - 1) - 1;
    localparam int          RAND_ITEMS  = 260;
    localparam int          CYCLE_LIMIT = 1000000;

    typedef struct packed {
        t_status                      status;
        logic [TASK_ID_BITS_DEF-1:0]  task_id;
        logic signed [COUNT_BITS_DEF-1:0] count;
        logic                         last;
    } sem_result_t;

    logic i_clk;
    logic i_rst_n;

    csq_cmd_if #(.TASK_ID_BITS(TASK_ID_BITS_DEF)) cmd_ch ();
    csq_res_if #(.TASK_ID_BITS(TASK_ID_BITS_DEF), .COUNT_BITS(COUNT_BITS_DEF)) res_ch ();
    csq_cfg_if #(.CFG_BITS(CFG_BITS)) cfg_ch ();

    counting_semaphore_wait_queue DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // semaphore model
    int                          sem_count;
    logic [TASK_ID_BITS_DEF-1:0] sem_waiters[$];
    bit                          sem_dead;
    sem_result_t                 pending_results[$];

    int err_count;
    int cycle_count;
    bit gaps_on;
    int long_hold;
    int random_sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("testbench: FAIL");
        $finish;
    end

    function automatic void push_result(t_status st, logic [TASK_ID_BITS_DEF-1:0] id,
                                        logic last);
        sem_result_t r;
        r.status  = st;
        r.task_id = id;
        r.count   = sem_count[COUNT_BITS_DEF-1:0];
        r.last    = last;
        pending_results.push_back(r);
    endfunction

    function automatic void sem_reinit(int init);
        sem_count = init;
        sem_waiters.delete();
        sem_dead = 1'b0;
    endfunction

    function automatic void semaphore_step(logic [1:0] cmd, logic [TASK_ID_BITS_DEF-1:0] id);
        if (cmd == CMD_UNUSED)
            return;
        if (sem_dead) begin
            push_result(ST_DEAD_ERR, '0, 1'b1);
            return;
        end
        case (cmd)
            CMD_DOWN: begin
                if (sem_count - 1 < 0) begin
                    if (sem_waiters.size() >= WAIT_DEPTH_DEF) begin
                        push_result(ST_FULL_ERR, '0, 1'b1);
                    end else begin
                        sem_waiters.push_back(id);
                        sem_count--;
                        push_result(ST_BLOCKED, id, 1'b1);
                    end
                end else begin
                    sem_count--;
                    push_result(ST_GRANTED, '0, 1'b1);
                end
            end
            CMD_UP: begin
                if (sem_count + 1 > COUNT_MAX) begin
                    push_result(ST_FULL_ERR, '0, 1'b1);
                end else begin
                    sem_count++;
                    if (sem_count <= 0 && sem_waiters.size() > 0)
                        push_result(ST_WOKEN, sem_waiters.pop_front(), 1'b1);
                    else
                        push_result(ST_GRANTED, '0, 1'b1);
                end
            end
            default: begin
                sem_dead = 1'b1;
                while (sem_waiters.size() > 0)
                    push_result(ST_DESTROY_WOKEN, sem_waiters.pop_front(), 1'b0);
                push_result(ST_DESTROY_DONE, '0, 1'b1);
            end
        endcase
    endfunction

    task automatic send_cmd(logic [1:0] cmd, logic [TASK_ID_BITS_DEF-1:0] id);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.task_id <= id;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        semaphore_step(cmd, id);
    endtask

    // register write only once the block has gone quiet
    task automatic write_initial_count(logic [CFG_BITS-1:0] value);
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.initial_count <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        sem_reinit((value > COUNT_MAX) ? COUNT_MAX : int'(value));
    endtask

    task automatic check_result();
        sem_result_t want;
        if (pending_results.size() == 0) begin
            $error("unexpected result: status %0d task %0d count %0d last %0d",
                   res_ch.status, res_ch.affected_task, res_ch.count_after, res_ch.last);
            err_count++;
            return;
        end
        want = pending_results.pop_front();
        if (res_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, res_ch.status);
            err_count++;
        end
        if (res_ch.affected_task !== want.task_id) begin
            $error("affected_task: expected %0d, actual %0d", want.task_id,
                   res_ch.affected_task);
            err_count++;
        end
        if (res_ch.count_after !== want.count) begin
            $error("count_after: expected %0d, actual %0d", want.count, res_ch.count_after);
            err_count++;
        end
        if (res_ch.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, res_ch.last);
            err_count++;
        end
    endtask

    // result sink: random stalls plus an optional long hold
    initial begin
        int stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready)
                check_result();
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (long_hold > 0) begin
                stall_left = long_hold - 1;
                long_hold  = 0;
                res_ch.ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic test_grant_block_wake();
        write_initial_count(15'd2);
        send_cmd(CMD_DOWN, 6'd0);
        send_cmd(CMD_DOWN, 6'd63);
        send_cmd(CMD_DOWN, 6'd21);
        send_cmd(CMD_DOWN, 6'd42);
        send_cmd(CMD_UNUSED, 6'd63);
        send_cmd(CMD_UP, 6'd0);
        send_cmd(CMD_UP, 6'd63);
        send_cmd(CMD_UP, 6'd5);
    endtask

    task automatic test_queue_full_and_destroy();
        write_initial_count(15'd0);
        for (int i = 0; i < WAIT_DEPTH_DEF; i++)
            send_cmd(CMD_DOWN, 6'($urandom_range(0, 63)));
        send_cmd(CMD_DOWN, 6'd63);
        send_cmd(CMD_DESTROY, 6'd0);
        send_cmd(CMD_DOWN, 6'd7);
        send_cmd(CMD_UP, 6'd7);
        send_cmd(CMD_DESTROY, 6'd0);
        send_cmd(CMD_UNUSED, 6'd0);
    endtask

    task automatic test_count_limit();
        write_initial_count(15'(COUNT_MAX));
        send_cmd(CMD_UP, 6'd0);
        send_cmd(CMD_DOWN, 6'd63);
        send_cmd(CMD_UP, 6'd63);
        send_cmd(CMD_UP, 6'd1);
    endtask

    task automatic test_backpressure();
        write_initial_count(15'd3);
        long_hold = 200;
        for (int i = 0; i < 30; i++)
            send_cmd(($urandom_range(0, 1) == 0) ? CMD_DOWN : CMD_UP,
                     6'($urandom_range(0, 63)));
        send_cmd(CMD_DESTROY, 6'd0);
    endtask

    function automatic logic [CFG_BITS-1:0] pick_initial_count();
        case ($urandom_range(0, 9))
            0:       return CFG_BITS'(COUNT_MAX);
            1:       return CFG_BITS'($urandom_range(COUNT_MAX - 3, COUNT_MAX));
            2:       return CFG_BITS'($urandom_range(0, COUNT_MAX));
            default: return CFG_BITS'($urandom_range(0, 4));
        endcase
    endfunction

    task automatic test_random();
        int phase_len;
        int down_pct;
        int pick;
        while (random_sent < RAND_ITEMS) begin
            write_initial_count(pick_initial_count());
            phase_len = $urandom_range(20, 45);
            down_pct  = $urandom_range(35, 65);
            for (int i = 0; i < phase_len && random_sent < RAND_ITEMS; i++) begin
                if (random_sent >= RAND_ITEMS - 60)
                    gaps_on = 1'b0;
                pick = $urandom_range(0, 99);
                if (pick < down_pct) begin
                    send_cmd(CMD_DOWN, 6'($urandom_range(0, 63)));
                    random_sent++;
                end else if (pick < 94) begin
                    send_cmd(CMD_UP, 6'($urandom_range(0, 63)));
                    random_sent++;
                end else if (pick < 97) begin
                    send_cmd(CMD_UNUSED, 6'($urandom_range(0, 63)));
                end else begin
                    send_cmd(CMD_DESTROY, 6'($urandom_range(0, 63)));
                    random_sent++;
                end
            end
            if ($urandom_range(0, 1) == 0) begin
                send_cmd(CMD_DESTROY, 6'($urandom_range(0, 63)));
                send_cmd(CMD_DOWN, 6'($urandom_range(0, 63)));
                random_sent += 2;
            end
        end
    endtask

    initial begin
        err_count   = 0;
        gaps_on     = 1'b1;
        long_hold   = 0;
        random_sent = 0;
        sem_reinit(0);
        i_rst_n              <= 1'b0;
        cmd_ch.valid         <= 1'b0;
        cmd_ch.command       <= CMD_DOWN;
        cmd_ch.task_id       <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.initial_count <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_grant_block_wake();
        test_queue_full_and_destroy();
        test_count_limit();
        test_backpressure();
        test_random();

        cmd_ch.valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (err_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
